// ===== rtl/core/tcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int DEF_SCREEN_WIDTH  = 80;
    localparam int DEF_SCREEN_HEIGHT = 25;

    localparam int CHAR_W   = 8;
    localparam int PROBE_W  = 11;
    localparam int CELL_W   = 16;
    localparam int COLOUR_W = 4;

    localparam int OUT_COL_W = 7;
    localparam int OUT_ROW_W = 5;
    localparam int OUT_POS_W = 11;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    localparam int CFG_INDEX_W = 1;

    localparam logic [CHAR_W-1:0]   CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0]   CHAR_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0]   CHAR_SPACE   = 8'h20;
    localparam int                  TAB_STEP     = 4;
    localparam logic [CELL_W-1:0]   BLANK_CELL   = 16'h0720;

    localparam logic [COLOUR_W-1:0] FG_RESET = 4'h7;
    localparam logic [COLOUR_W-1:0] BG_RESET = 4'h0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FOREGROUND = 1'b0,
        REG_BACKGROUND = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [COLOUR_W-1:0] bg;
        logic [COLOUR_W-1:0] fg;
    } attr_t;

endpackage

`default_nettype wire

// ===== rtl/core/text_console_writer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Text console writer: each request carries a character code and a probe index; the
// block updates a SCREEN_WIDTH x SCREEN_HEIGHT screen of 16-bit cells held in one
// synchronous memory and answers with the new cursor, a scroll flag and the cell
// read back at the probe index. Without a scroll, the probe read and, for a printable
// character, the cell write happen in the accepting cycle; the result register is
// loaded once the output is free. A wrap or newline on the last row walks the memory
// with one read and one write per cycle to move each row up, then fills the last row
// with spaces in the current colours. After reset all cells are cleared to blank
// grey-on-black before the first request is taken. A new request is taken while the
// previous result is still waiting on the output. Colour registers are written
// through the cfg port and should only change while the block is idle.

module text_console_writer_core #(
    parameter int SCREEN_WIDTH  = tcw_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tcw_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_wr_en,
    input  wire  [tcw_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire  [tcw_pkg::COLOUR_W-1:0]     cfg_wdata,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // char_code [7:0], probe_index [18:8], zero padding above.
    input  wire  [tcw_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // cursor_column [6:0], cursor_row [11:7], cursor_position [22:12],
    // scrolled [23], probe_entry [39:24].
    output logic [tcw_pkg::M_TDATA_W-1:0]    m_tdata
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    attr_t              attr_reg;
    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [CELL_W-1:0]  ram_wr_data;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [CELL_W-1:0]  ram_rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg.fg <= FG_RESET;
            attr_reg.bg <= BG_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_FOREGROUND: attr_reg.fg <= cfg_wdata;
                REG_BACKGROUND: attr_reg.bg <= cfg_wdata;
                default: attr_reg <= attr_reg;
            endcase
        end
    end

    tcw_ctrl #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .ADDR_W        (ADDR_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .attr        (attr_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_char      (s_tdata[CHAR_W-1:0]),
        .s_probe     (s_tdata[CHAR_W+PROBE_W-1:CHAR_W]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    tcw_screen_ram #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_screen_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

// ===== rtl/core/tcw_screen_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_screen_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  wire                         aclk,
    input  wire                         wr_en,
    input  wire  [ADDR_W-1:0]           wr_addr,
    input  wire  [tcw_pkg::CELL_W-1:0]  wr_data,
    input  wire                         rd_en,
    input  wire  [ADDR_W-1:0]           rd_addr,
    output logic [tcw_pkg::CELL_W-1:0]  rd_data
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tcw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25,
    parameter int ADDR_W        = 11
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire  tcw_pkg::attr_t           attr,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [tcw_pkg::CHAR_W-1:0]     s_char,
    input  wire  [tcw_pkg::PROBE_W-1:0]    s_probe,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [tcw_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           ram_wr_en,
    output logic [ADDR_W-1:0]              ram_wr_addr,
    output logic [tcw_pkg::CELL_W-1:0]     ram_wr_data,
    output logic                           ram_rd_en,
    output logic [ADDR_W-1:0]              ram_rd_addr,
    input  wire  [tcw_pkg::CELL_W-1:0]     ram_rd_data
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int COL_W      = $clog2(SCREEN_WIDTH);
    localparam int ROW_W      = $clog2(SCREEN_HEIGHT);
    localparam int LAST_ROW   = SCREEN_HEIGHT - 1;
    localparam int LAST_POS   = LAST_ROW * SCREEN_WIDTH;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_COPY  = 6'b000100,
        ST_FILL  = 6'b001000,
        ST_PROBE = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [ROW_W-1:0]       row_reg, row_next;
    logic [ADDR_W-1:0]      pos_reg, pos_next;
    logic [ADDR_W-1:0]      walk_reg, walk_next;
    logic                   cp_valid_reg, cp_valid_next;
    logic [ADDR_W-1:0]      cp_addr_reg, cp_addr_next;
    logic [PROBE_W-1:0]     probe_reg, probe_next;
    logic                   probe_ok_reg, probe_ok_next;
    logic                   fwd_hit_reg, fwd_hit_next;
    logic [CELL_W-1:0]      fwd_data_reg, fwd_data_next;
    logic                   scrolled_reg, scrolled_next;
    logic                   m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;

    logic                   accept;
    logic                   is_newline;
    logic                   is_tab;
    logic                   is_print;
    logic [COL_W:0]         col_tab;
    logic [COL_W:0]         col_inc;
    logic                   wrap;
    logic                   last_row;
    logic [ADDR_W:0]        line_start;
    logic [CELL_W-1:0]      char_cell;
    logic [CELL_W-1:0]      fill_cell;
    logic [CELL_W-1:0]      probe_data;
    logic                   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;

    assign is_newline = (s_char == CHAR_NEWLINE);
    assign is_tab     = (s_char == CHAR_TAB);
    assign is_print   = !is_newline && !is_tab;
    assign col_tab    = {1'b0, col_reg} + (COL_W + 1)'(TAB_STEP);
    assign col_inc    = {1'b0, col_reg} + (COL_W + 1)'(1);
    assign wrap       = is_newline
                     || (is_tab && (col_tab >= (COL_W + 1)'(SCREEN_WIDTH)))
                     || (is_print && (col_inc >= (COL_W + 1)'(SCREEN_WIDTH)));
    assign last_row   = (row_reg == ROW_W'(LAST_ROW));
    assign line_start = {1'b0, pos_reg} - (ADDR_W + 1)'(col_reg)
                      + (ADDR_W + 1)'(SCREEN_WIDTH);
    assign char_cell  = {attr, s_char};
    assign fill_cell  = {attr, CHAR_SPACE};
    assign probe_data = !probe_ok_reg ? '0 : (fwd_hit_reg ? fwd_data_reg : ram_rd_data);

    always_comb begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        pos_next      = pos_reg;
        walk_next     = walk_reg;
        cp_valid_next = 1'b0;
        cp_addr_next  = cp_addr_reg;
        probe_next    = probe_reg;
        probe_ok_next = probe_ok_reg;
        fwd_hit_next  = fwd_hit_reg;
        fwd_data_next = fwd_data_reg;
        scrolled_next = scrolled_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        ram_wr_en     = cp_valid_reg;
        ram_wr_addr   = cp_addr_reg;
        ram_wr_data   = ram_rd_data;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = walk_reg;

        case (state_reg)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = walk_reg;
                ram_wr_data = BLANK_CELL;
                if (walk_reg == ADDR_W'(CELL_COUNT - 1)) begin
                    walk_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    walk_next = walk_reg + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    probe_next    = s_probe;
                    probe_ok_next = ({21'd0, s_probe} < 32'(CELL_COUNT));
                    scrolled_next = 1'b0;
                    if (is_print) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = pos_reg;
                        ram_wr_data = char_cell;
                    end
                    if (wrap) begin
                        col_next = '0;
                        if (last_row) begin
                            pos_next      = ADDR_W'(LAST_POS);
                            scrolled_next = 1'b1;
                        end else begin
                            row_next = row_reg + ROW_W'(1);
                            pos_next = line_start[ADDR_W-1:0];
                        end
                    end else if (is_tab) begin
                        col_next = col_tab[COL_W-1:0];
                        pos_next = pos_reg + ADDR_W'(TAB_STEP);
                    end else begin
                        col_next = col_inc[COL_W-1:0];
                        pos_next = pos_reg + ADDR_W'(1);
                    end
                    if (wrap && last_row) begin
                        walk_next    = ADDR_W'(SCREEN_WIDTH);
                        fwd_hit_next = 1'b0;
                        state_next   = ST_COPY;
                    end else begin
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = ADDR_W'(s_probe);
                        fwd_hit_next  = is_print && ({21'd0, s_probe} == 32'(pos_reg));
                        fwd_data_next = char_cell;
                        state_next    = ST_DONE;
                    end
                end
            end
            ST_COPY: begin
                ram_rd_en     = 1'b1;
                ram_rd_addr   = walk_reg;
                cp_valid_next = 1'b1;
                cp_addr_next  = walk_reg - ADDR_W'(SCREEN_WIDTH);
                if (walk_reg == ADDR_W'(CELL_COUNT - 1)) begin
                    walk_next  = ADDR_W'(LAST_POS);
                    state_next = ST_FILL;
                end else begin
                    walk_next = walk_reg + ADDR_W'(1);
                end
            end
            ST_FILL: begin
                if (!cp_valid_reg) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = walk_reg;
                    ram_wr_data = fill_cell;
                    if (walk_reg == ADDR_W'(CELL_COUNT - 1)) begin
                        walk_next  = '0;
                        state_next = ST_PROBE;
                    end else begin
                        walk_next = walk_reg + ADDR_W'(1);
                    end
                end
            end
            ST_PROBE: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = ADDR_W'(probe_reg);
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {probe_data, scrolled_reg, OUT_POS_W'(pos_reg),
                                    OUT_ROW_W'(row_reg), OUT_COL_W'(col_reg)};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                walk_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            col_reg      <= '0;
            row_reg      <= '0;
            pos_reg      <= '0;
            walk_reg     <= '0;
            cp_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            pos_reg      <= pos_next;
            walk_reg     <= walk_next;
            cp_valid_reg <= cp_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cp_addr_reg  <= cp_addr_next;
        probe_reg    <= probe_next;
        probe_ok_reg <= probe_ok_next;
        fwd_hit_reg  <= fwd_hit_next;
        fwd_data_reg <= fwd_data_next;
        scrolled_reg <= scrolled_next;
        m_data_reg   <= m_data_next;
    end

`ifndef ASSERT_OFF
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(col_reg) < SCREEN_WIDTH)
        else $error("Cursor column has left the screen.");

    a_pos_tracks_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(pos_reg) == 32'(row_reg) * SCREEN_WIDTH + 32'(col_reg))
        else $error("Linear cursor position disagrees with row and column.");

    a_scroll_on_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY || state_reg == ST_FILL) |-> last_row)
        else $error("Screen scroll running while the cursor is not on the last row.");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("Result presented without a finished request.");
`endif

endmodule

`default_nettype wire
